// File: sv/gemm_pkg.sv
`default_nettype none
package gemm_pkg;
    localparam int MAX_DIM = 64;
    localparam int STORE_DEPTH = 4096;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CFG_IW = 3;

    typedef enum logic [2:0] {
        MODE_LOAD_A  = 3'd0,
        MODE_LOAD_B  = 3'd1,
        MODE_LOAD_C  = 3'd2,
        MODE_COMPUTE = 3'd3,
        MODE_READ_C  = 3'd4
    } mode_t;

    localparam logic [CFG_IW-1:0] REG_TRANSPOSE = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ROWS_M    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_COLS_N    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_INNER_K   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_ALPHA     = 3'd4;
    localparam logic [CFG_IW-1:0] REG_BETA      = 3'd5;
    localparam logic [CFG_IW-1:0] REG_STRIDE_A  = 3'd6;
    localparam logic [CFG_IW-1:0] REG_STRIDE_B  = 3'd7;

    typedef struct packed {
        logic [2:0]        mode;
        logic [AW-1:0]     addr;
        logic signed [31:0] value;
        logic              bad;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         tmode;
        logic [DW-1:0]      m;
        logic [DW-1:0]      n;
        logic [DW-1:0]      k;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic [DW-1:0]      sa;
        logic [DW-1:0]      sb;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// File: sv/gemm_alpha_beta_transpose.sv
`default_nettype none
// GEMM engine, C = beta*C + alpha*op(A)*op(B) in signed Q16.16, with A, B and C held in
// on-chip stores of 4096 words each. Load, read and unknown-mode requests go through the
// single-ported stores; a compute request works through all M*N results one after another,
// paced by the one multiply-accumulate unit and the one read port per store. One result
// per request, status 1 on an out-of-range address or dimension.
module gemm_alpha_beta_transpose (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // mode, elem_addr, elem_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // read_value, status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import gemm_pkg::*;
    cfg_t cfg_reg;
    cmd_t q_data;
    logic q_valid, q_pop;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tmode <= '0;
            cfg_reg.m <= DW'(1); cfg_reg.n <= DW'(1); cfg_reg.k <= DW'(1);
            cfg_reg.alpha <= 32'sd65536; cfg_reg.beta <= 32'sd65536;
            cfg_reg.sa <= DW'(1); cfg_reg.sb <= DW'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TRANSPOSE: cfg_reg.tmode <= cfg_data[1:0];
                REG_ROWS_M:    cfg_reg.m <= cfg_data[6:0];
                REG_COLS_N:    cfg_reg.n <= cfg_data[6:0];
                REG_INNER_K:   cfg_reg.k <= cfg_data[6:0];
                REG_ALPHA:     cfg_reg.alpha <= cfg_data;
                REG_BETA:      cfg_reg.beta <= cfg_data;
                REG_STRIDE_A:  cfg_reg.sa <= cfg_data[6:0];
                REG_STRIDE_B:  cfg_reg.sb <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    gemm_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .cfg(cfg_reg), .q_data, .q_valid, .q_pop
    );
    gemm_back u_back (
        .aclk, .aresetn, .cfg(cfg_reg), .q_data, .q_valid, .q_pop,
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule
`default_nettype wire

// File: sv/gemm_front.sv
`default_nettype none
module gemm_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [47:0]   s_tdata,
    input  wire gemm_pkg::cfg_t cfg,
    output gemm_pkg::cmd_t     q_data,
    output logic               q_valid,
    input  wire logic          q_pop
);
    import gemm_pkg::*;
    localparam int QD = 2;
    cmd_t q_reg [QD];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_reg, wr_reg;
    cmd_t c;
    logic [2:0] md;
    logic [11:0] ad;
    logic dok;
    logic [15:0] amax, bmax, cmax;
    logic push;

    assign md = s_tdata[2:0];
    assign ad = s_tdata[14:3];
    assign s_tready = cnt_reg < 2'(QD);
    assign push = s_tvalid && s_tready;

    always_comb begin
        dok = cfg.m >= 1 && cfg.m <= DW'(MAX_DIM) && cfg.n >= 1 && cfg.n <= DW'(MAX_DIM)
            && cfg.k >= 1 && cfg.k <= DW'(MAX_DIM) && cfg.sa >= 1 && cfg.sa <= DW'(MAX_DIM)
            && cfg.sb >= 1 && cfg.sb <= DW'(MAX_DIM);
        amax = cfg.tmode[0] ? 16'((cfg.k - 1'b1) * cfg.sa + (cfg.m - 1'b1))
                            : 16'((cfg.m - 1'b1) * cfg.sa + (cfg.k - 1'b1));
        bmax = cfg.tmode[1] ? 16'((cfg.n - 1'b1) * cfg.sb + (cfg.k - 1'b1))
                            : 16'((cfg.k - 1'b1) * cfg.sb + (cfg.n - 1'b1));
        cmax = 16'(cfg.m * cfg.n - 1'b1);
        c.mode = md;
        c.addr = AW'(ad);
        c.value = s_tdata[46:15];
        if (md == MODE_COMPUTE)
            c.bad = !dok || amax >= 16'(STORE_DEPTH) || bmax >= 16'(STORE_DEPTH)
                  || cmax >= 16'(STORE_DEPTH);
        else if (md <= MODE_READ_C)
            c.bad = 17'(ad) >= 17'(STORE_DEPTH);
        else
            c.bad = 1'b0;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    assign q_valid = cnt_reg != 0;
    assign q_data = q_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= !wr_reg;
            if (q_pop) rd_reg <= !rd_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_reg] <= c;
    end
endmodule
`default_nettype wire

// File: sv/gemm_back.sv
`default_nettype none
module gemm_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire gemm_pkg::cfg_t cfg,
    input  wire gemm_pkg::cmd_t q_data,
    input  wire logic           q_valid,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [39:0]         m_tdata
);
    import gemm_pkg::*;
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_RDLAT = 9'b000000010, S_ADDR = 9'b000000100,
        S_MUL  = 9'b000001000, S_ACC  = 9'b000010000, S_CRD  = 9'b000100000,
        S_GAIN = 9'b001000000, S_WB   = 9'b010000000, S_DONE = 9'b100000000
    } state_t;
    state_t st_reg, st_next;

    logic [31:0] a_mem [STORE_DEPTH];
    logic [31:0] b_mem [STORE_DEPTH];
    logic [31:0] c_mem [STORE_DEPTH];
    logic signed [31:0] a_q, b_q, c_q;
    logic [AW-1:0] a_addr, b_addr, c_addr;
    logic a_we, b_we, c_we;
    logic [31:0] c_wd;

    logic [DW-1:0] i_reg, j_reg, q_reg;
    logic [AW-1:0] ci_reg;
    logic signed [63:0] prod_reg;
    logic signed [55:0] acc_reg;
    logic signed [63:0] t0_reg, t1_reg;
    logic signed [31:0] dot;
    logic last_q_reg, kdone_reg;
    logic ovalid_reg;
    logic [31:0] orv_reg;
    logic ost_reg;
    logic obusy;

    assign obusy = ovalid_reg && !m_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata = {7'd0, ost_reg, orv_reg};

    always_comb begin
        if (cfg.tmode[0]) a_addr = AW'(q_reg * cfg.sa + i_reg);
        else a_addr = AW'(i_reg * cfg.sa + q_reg);
        if (cfg.tmode[1]) b_addr = AW'(j_reg * cfg.sb + q_reg);
        else b_addr = AW'(q_reg * cfg.sb + j_reg);
        a_we = 1'b0; b_we = 1'b0; c_we = 1'b0;
        c_wd = q_data.value;
        c_addr = ci_reg;
        if (st_reg == S_IDLE && q_valid && !obusy && !q_data.bad) begin
            a_we = q_data.mode == MODE_LOAD_A;
            b_we = q_data.mode == MODE_LOAD_B;
            c_we = q_data.mode == MODE_LOAD_C;
        end
        if (st_reg == S_IDLE) c_addr = q_data.addr;
        if (a_we) a_addr = q_data.addr;
        if (b_we) b_addr = q_data.addr;
        if (st_reg == S_WB) begin
            c_we = 1'b1;
            c_wd = sat32(66'(t0_reg >>> 16) + 66'(t1_reg >>> 16));
        end
        dot = sat32(66'(acc_reg));
    end

    always_ff @(posedge aclk) begin
        if (a_we) a_mem[a_addr] <= q_data.value;
        a_q <= a_mem[a_addr];
        if (b_we) b_mem[b_addr] <= q_data.value;
        b_q <= b_mem[b_addr];
        if (c_we) c_mem[c_addr] <= c_wd;
        c_q <= c_mem[c_addr];
    end

    always_comb begin
        st_next = st_reg;
        q_pop = 1'b0;
        unique case (st_reg)
            S_IDLE: if (q_valid && !obusy) begin
                if (q_data.mode == MODE_COMPUTE && !q_data.bad) st_next = S_ADDR;
                else if (q_data.mode == MODE_READ_C && !q_data.bad) st_next = S_RDLAT;
                else q_pop = 1'b1;
            end
            S_RDLAT: begin
                q_pop = 1'b1;
                st_next = S_IDLE;
            end
            S_ADDR: st_next = S_MUL;
            S_MUL: st_next = S_ACC;
            S_ACC: st_next = kdone_reg ? S_CRD : S_ACC;
            S_CRD: st_next = S_GAIN;
            S_GAIN: st_next = S_WB;
            S_WB: st_next = (i_reg == cfg.m - 1'b1 && j_reg == cfg.n - 1'b1) ? S_DONE : S_ADDR;
            S_DONE: if (!obusy) begin
                q_pop = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (q_pop) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            orv_reg <= (st_reg == S_RDLAT) ? c_q : 32'd0;
            ost_reg <= q_data.bad;
        end
        kdone_reg <= 1'b0;
        unique case (st_reg)
            S_IDLE: begin
                i_reg <= '0; j_reg <= '0; q_reg <= '0; ci_reg <= '0;
                acc_reg <= '0;
            end
            S_ADDR: begin
                last_q_reg <= q_reg == cfg.k - 1'b1;
                if (q_reg != cfg.k - 1'b1) q_reg <= q_reg + 1'b1;
            end
            S_MUL: begin
                prod_reg <= a_q * b_q;
                kdone_reg <= last_q_reg;
                last_q_reg <= q_reg == cfg.k - 1'b1;
                if (q_reg != cfg.k - 1'b1) q_reg <= q_reg + 1'b1;
            end
            S_ACC: begin
                acc_reg <= acc_reg + 56'(prod_reg >>> 16);
                if (!kdone_reg) begin
                    prod_reg <= a_q * b_q;
                    kdone_reg <= last_q_reg;
                    last_q_reg <= q_reg == cfg.k - 1'b1;
                    if (q_reg != cfg.k - 1'b1) q_reg <= q_reg + 1'b1;
                end
            end
            S_CRD: t1_reg <= cfg.alpha * dot;
            S_GAIN: t0_reg <= cfg.beta * c_q;
            S_WB: begin
                acc_reg <= '0;
                q_reg <= '0;
                ci_reg <= ci_reg + 1'b1;
                if (j_reg == cfg.n - 1'b1) begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/gemm_checker.sv
`default_nettype none
module gemm_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:33] == 7'd0) else $error("pad bits set");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0) else $error("error with data");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid) else $error("valid in reset");
endmodule
bind gemm_alpha_beta_transpose gemm_props u_chk (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
